// ===== design/int_to_ascii_dec_hex_formatter_assert.svh =====
// Assertion macros for the integer to ASCII formatter.
// Each macro expects clk and rst_n in scope.
`ifndef INT_TO_ASCII_DEC_HEX_FORMATTER_ASSERT_SVH
`define INT_TO_ASCII_DEC_HEX_FORMATTER_ASSERT_SVH

// Same-cycle implication.
`define ITADF_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("formatter assertion failed");

// Next-cycle implication.
`define ITADF_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("formatter assertion failed");

`endif

// ===== design/itadf_pkg.sv =====
`timescale 1ns / 1ps

package itadf_pkg;

  localparam logic [1:0] CMD_SDEC = 2'd0;
  localparam logic [1:0] CMD_UDEC = 2'd1;
  localparam logic [1:0] CMD_HEXL = 2'd2;
  localparam logic [1:0] CMD_HEXU = 2'd3;

  localparam int NUM_DIGITS     = 10;
  localparam int BITS_PER_STAGE = 4;
  localparam int DD_STAGES      = 32 / BITS_PER_STAGE;

  localparam logic [3:0] MAX_MIN_DIGITS = 4'd9;

  localparam logic [6:0] ASCII_MINUS = 7'h2d;
  localparam logic [6:0] ASCII_ZERO  = 7'h30;
  localparam logic [6:0] ASCII_UA    = 7'h41;
  localparam logic [6:0] ASCII_LA    = 7'h61;

  typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

  // One word in flight through the conversion stages.
  typedef struct packed {
    logic [1:0]  mode;
    logic        neg;
    logic [3:0]  min_dig;
    logic [31:0] mag;
    logic [31:0] bin;
    digits_t     bcd;
  } stage_t;

  // Request handed to the serializer.
  typedef struct packed {
    digits_t    digits;
    logic [3:0] top;
    logic       neg;
    logic       upper;
  } ser_req_t;

  // Shift four binary bits, MSB first, into the BCD register.
  function automatic digits_t dabble4(input digits_t bcd_in, input logic [3:0] bits);
    digits_t                 acc;
    logic [4*NUM_DIGITS-1:0] flat;
    acc = bcd_in;
    for (int s = 3; s >= 0; s--) begin
      for (int j = 0; j < NUM_DIGITS; j++) begin
        if (acc[j] >= 4'd5) begin
          acc[j] = acc[j] + 4'd3;
        end
      end
      flat = acc;
      acc  = {flat[4*NUM_DIGITS-2:0], bits[s]};
    end
    return acc;
  endfunction

  function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
    logic [6:0] base;
    base = upper ? ASCII_UA : ASCII_LA;
    if (d < 4'd10) begin
      return ASCII_ZERO + {3'd0, d};
    end
    return base + {3'd0, d} - 7'd10;
  endfunction

endpackage

// ===== design/itadf_serializer.sv =====
`timescale 1ns / 1ps

module itadf_serializer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 req_valid,
  input  itadf_pkg::ser_req_t  req,
  output logic                 req_ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [6:0]           out_character,
  output logic                 out_last
);

  logic                busy_r;
  logic                sign_r;
  logic                upper_r;
  logic [3:0]          idx_r;
  itadf_pkg::digits_t  digits_r;
  logic                out_valid_r;
  logic [6:0]          char_r;
  logic                last_r;
  logic                out_take;

  assign out_take  = !out_valid_r || !out_stall;
  // Take a new request when idle, or while the last character of the current one leaves.
  assign req_ready = !busy_r || (out_take && !sign_r && (idx_r == 4'd0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      sign_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_take) begin
        out_valid_r <= busy_r;
        if (busy_r) begin
          if (sign_r) begin
            char_r <= itadf_pkg::ASCII_MINUS;
            last_r <= 1'b0;
          end else begin
            char_r <= itadf_pkg::digit_char(digits_r[idx_r], upper_r);
            last_r <= (idx_r == 4'd0);
          end
        end
      end
      // Load a fresh request, else advance through the current one.
      if (req_valid && req_ready) begin
        busy_r   <= 1'b1;
        sign_r   <= req.neg;
        upper_r  <= req.upper;
        idx_r    <= req.top;
        digits_r <= req.digits;
      end else if (out_take && busy_r) begin
        if (sign_r) begin
          sign_r <= 1'b0;
        end else if (idx_r == 4'd0) begin
          busy_r <= 1'b0;
        end else begin
          idx_r <= idx_r - 4'd1;
        end
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = char_r;
  assign out_last      = last_r;

endmodule

// ===== design/int_to_ascii_dec_hex_formatter.sv =====
`timescale 1ns / 1ps

// Integer to ASCII formatter. Each request carries a 32-bit word, a mode
// (signed decimal, unsigned decimal, lower or upper hex) and a minimum digit
// count; the block returns the text one ASCII character per result, most
// significant digit first, with out_last on the final one. Negative words in
// signed mode lead with '-'. A request passes an input stage, eight binary to
// BCD stages (four bits each) and a format stage before the output register.
// A new request may enter every cycle while the pipeline has room; sustained
// rate is set by the single output register, which sends one character per
// cycle while out_stall is low: a request's string (sign plus digits) holds
// 1 to 11 characters.
module int_to_ascii_dec_hex_formatter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_value,
  input  logic [3:0]  in_min_digits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_character,
  output logic        out_last
);

  localparam int NS = itadf_pkg::DD_STAGES;

  itadf_pkg::stage_t   stg_r [0:NS];
  itadf_pkg::stage_t   stg_nxt [0:NS];
  logic [NS:0]         v_r;
  logic [NS:0]         rdy;

  itadf_pkg::ser_req_t fmt_r;
  itadf_pkg::ser_req_t fmt_nxt;
  logic                fv_r;
  logic                fmt_ready;
  logic                ser_ready;

  // Ready chain: a stage advances when it is empty or its successor moves.
  always_comb begin
    fmt_ready = !fv_r || ser_ready;
    rdy[NS] = !v_r[NS] || fmt_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0];

  always_comb begin
    // Input stage: take the magnitude, note the sign, clamp the digit count.
    stg_nxt[0].mode    = in_command;
    stg_nxt[0].neg     = (in_command == itadf_pkg::CMD_SDEC) && in_value[31];
    stg_nxt[0].mag     = stg_nxt[0].neg ? (32'd0 - in_value) : in_value;
    stg_nxt[0].bin     = stg_nxt[0].mag;
    stg_nxt[0].bcd     = '0;
    stg_nxt[0].min_dig = (in_min_digits > itadf_pkg::MAX_MIN_DIGITS) ?
                         itadf_pkg::MAX_MIN_DIGITS : in_min_digits;
    // Conversion stages: shift four magnitude bits into the BCD digits each.
    for (int k = 1; k <= NS; k++) begin
      stg_nxt[k]     = stg_r[k-1];
      stg_nxt[k].bcd = itadf_pkg::dabble4(stg_r[k-1].bcd, stg_r[k-1].bin[31:28]);
      stg_nxt[k].bin = {stg_r[k-1].bin[27:0], 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k <= NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Payload registers: load only when the feeding side holds a request.
  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      stg_r[0] <= stg_nxt[0];
    end
    for (int k = 1; k <= NS; k++) begin
      if (rdy[k] && v_r[k-1]) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  // Format stage: pick the digit set and find the first digit to print,
  // the highest nonzero one or the one the minimum count forces.
  always_comb begin
    logic hex;
    hex = stg_r[NS].mode[1];
    fmt_nxt.digits = hex ? {8'd0, stg_r[NS].mag} : stg_r[NS].bcd;
    fmt_nxt.neg    = stg_r[NS].neg;
    fmt_nxt.upper  = (stg_r[NS].mode == itadf_pkg::CMD_HEXU);
    fmt_nxt.top    = 4'd0;
    for (int i = 0; i < itadf_pkg::NUM_DIGITS; i++) begin
      if ((fmt_nxt.digits[i] != 4'd0) || (4'(i) < stg_r[NS].min_dig)) begin
        fmt_nxt.top = 4'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (fmt_ready) begin
      fv_r <= v_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (fmt_ready && v_r[NS]) begin
      fmt_r <= fmt_nxt;
    end
  end

  // Drive characters out one per cycle while out_stall is low.
  itadf_serializer u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (fv_r),
    .req           (fmt_r),
    .req_ready     (ser_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

`include "int_to_ascii_dec_hex_formatter_assert.svh"

  // A minus sign never ends a string.
  `ITADF_ASSERT_NOW(a_minus_not_last, out_valid && (out_character == itadf_pkg::ASCII_MINUS), !out_last)
  // Once the sign leaves, the first digit follows at once.
  `ITADF_ASSERT_NEXT(a_digit_after_minus, out_valid && !out_stall && (out_character == itadf_pkg::ASCII_MINUS), out_valid)
  // Only signed decimal requests carry a sign.
  `ITADF_ASSERT_NOW(a_sign_only_sdec, v_r[0] && stg_r[0].neg, stg_r[0].mode == itadf_pkg::CMD_SDEC)

endmodule

// ===== tb/tb_int_to_ascii_dec_hex_formatter.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the integer to ASCII formatter.
module tb_int_to_ascii_dec_hex_formatter;

  // Generous cycle budget: ~130 requests, each up to 11 characters, each
  // character waiting out a random stall, plus input gaps.
  localparam int CYCLE_LIMIT = 200000;
  // Drain for longer than the pipeline is deep.
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] value;
    logic [3:0]  min_digits;
  } fmt_request_t;

  typedef struct {
    logic [6:0] ch;
    logic       last;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = '0;
  logic [31:0] in_value = '0;
  logic [3:0]  in_min_digits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  out_character;
  logic        out_last;

  fmt_request_t pending_reqs[$];
  text_char_t   expected_text[$];

  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  int   in_gap = 0;
  int   stall_left = 0;
  int   cycle_cnt = 0;
  int   req_cnt = 0;
  int   char_cnt = 0;
  int   error_cnt = 0;

  int_to_ascii_dec_hex_formatter uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_value     (in_value),
    .in_min_digits(in_min_digits),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_character(out_character),
    .out_last     (out_last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Predict the text for one request and queue its characters.
  function automatic void predict_text(input logic [1:0] cmd, input logic [31:0] value,
                                       input logic [3:0] min_digits);
    logic [31:0] mag;
    logic [3:0]  dig [0:9];
    logic [6:0]  chars[$];
    logic [6:0]  alpha;
    int          floor_cnt;
    int          npos;
    bit          hex;
    bit          shown;
    text_char_t  tc;
    floor_cnt = (min_digits > itadf_pkg::MAX_MIN_DIGITS) ?
                int'(itadf_pkg::MAX_MIN_DIGITS) : int'(min_digits);
    hex = (cmd == itadf_pkg::CMD_HEXL) || (cmd == itadf_pkg::CMD_HEXU);
    alpha = (cmd == itadf_pkg::CMD_HEXU) ? itadf_pkg::ASCII_UA : itadf_pkg::ASCII_LA;
    shown = 1'b0;
    mag = value;
    // Signed mode: lead with the sign and continue on the magnitude.
    if (cmd == itadf_pkg::CMD_SDEC && value[31]) begin
      chars.push_back(itadf_pkg::ASCII_MINUS);
      mag = -value;
    end
    for (int i = 0; i < 10; i++) begin
      if (hex) begin
        dig[i] = mag[3:0];
        mag = mag >> 4;
      end else begin
        dig[i] = 4'(mag % 10);
        mag = mag / 10;
      end
    end
    npos = hex ? 9 : 10;
    // Drop leading zeros unless padding or the units digit keeps them.
    for (int i = npos - 1; i >= 0; i--) begin
      if (!(dig[i] == 4'd0 && i != 0 && !shown && floor_cnt <= i)) begin
        if (dig[i] < 4'd10) begin
          chars.push_back(itadf_pkg::ASCII_ZERO + 7'(dig[i]));
        end else begin
          chars.push_back(alpha + 7'(dig[i]) - 7'd10);
        end
        shown = 1'b1;
      end
    end
    foreach (chars[k]) begin
      tc.ch = chars[k];
      tc.last = (k == chars.size() - 1);
      expected_text.push_back(tc);
    end
  endfunction

  function automatic void add_request(input logic [1:0] cmd, input logic [31:0] value,
                                      input logic [3:0] min_digits);
    fmt_request_t r;
    r.cmd = cmd;
    r.value = value;
    r.min_digits = min_digits;
    pending_reqs.push_back(r);
  endfunction

  // Spread values over full words, short numbers, decade edges and the sign.
  function automatic logic [31:0] pick_value();
    logic [31:0] pow10 [0:9];
    int          k;
    pow10 = '{32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000,
              32'd10000000, 32'd100000000, 32'd1000000000};
    case ($urandom_range(0, 6))
      0: return $urandom_range(0, 99);
      1: begin
        k = $urandom_range(0, 9);
        return pow10[k] + $urandom_range(0, 2) - 1;
      end
      2: return 32'h8000_0000 + $urandom_range(0, 3) - 2;
      3: return 32'd1 << $urandom_range(0, 31);
      4: return $urandom >> $urandom_range(0, 31);
      5: return -$urandom_range(1, 1000);
      default: return $urandom;
    endcase
  endfunction

  // Stimulus: directed corners, then random requests, then drain and judge.
  initial begin
    // Zero in every mode, with and without padding.
    add_request(itadf_pkg::CMD_SDEC, 32'd0, 4'd0);
    add_request(itadf_pkg::CMD_SDEC, 32'd0, 4'd1);
    add_request(itadf_pkg::CMD_UDEC, 32'd0, 4'd0);
    add_request(itadf_pkg::CMD_HEXU, 32'd0, 4'd0);
    add_request(itadf_pkg::CMD_HEXL, 32'd0, 4'd9);
    add_request(itadf_pkg::CMD_SDEC, 32'd0, 4'd9);
    add_request(itadf_pkg::CMD_UDEC, 32'd0, 4'd15);
    // Sign handling, including the most negative word.
    add_request(itadf_pkg::CMD_SDEC, 32'h8000_0000, 4'd0);
    add_request(itadf_pkg::CMD_SDEC, 32'h8000_0000, 4'd12);
    add_request(itadf_pkg::CMD_SDEC, 32'hFFFF_FFFF, 4'd0);
    add_request(itadf_pkg::CMD_SDEC, 32'h7FFF_FFFF, 4'd9);
    add_request(itadf_pkg::CMD_SDEC, 32'hFFFF_FFFB, 4'd9);
    add_request(itadf_pkg::CMD_SDEC, 32'hFFFF_FFF6, 4'd3);
    // Top bit set in unsigned mode never yields a sign.
    add_request(itadf_pkg::CMD_UDEC, 32'hFFFF_FFFF, 4'd0);
    add_request(itadf_pkg::CMD_UDEC, 32'h8000_0000, 4'd15);
    add_request(itadf_pkg::CMD_UDEC, 32'd1234567890, 4'd5);
    add_request(itadf_pkg::CMD_UDEC, 32'd1000000000, 4'd0);
    // Hex letters in both cases, nine-digit padding, saturated minimum.
    add_request(itadf_pkg::CMD_HEXL, 32'hDEAD_BEEF, 4'd0);
    add_request(itadf_pkg::CMD_HEXU, 32'hDEAD_BEEF, 4'd9);
    add_request(itadf_pkg::CMD_HEXL, 32'hABCD_EF01, 4'd10);
    add_request(itadf_pkg::CMD_HEXU, 32'h0000_F00D, 4'd4);
    add_request(itadf_pkg::CMD_HEXU, 32'hFFFF_FFFF, 4'd15);
    add_request(itadf_pkg::CMD_HEXL, 32'h0000_0010, 4'd1);

    repeat (107) begin
      // Keep the minimum mostly in range; sometimes exercise saturation.
      add_request(2'($urandom_range(0, 3)), pick_value(),
                  ($urandom_range(0, 4) == 0) ? 4'($urandom_range(10, 15))
                                              : 4'($urandom_range(0, 9)));
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every request to be taken, then for all text to come back.
    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    // Flush the pipeline to catch stray characters.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_cnt == 0 && expected_text.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Request driver: present the queue head, hold it while stalled, then
  // idle for a random gap. Every fourth block of sixteen requests runs
  // back to back.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_taken) begin
        void'(pending_reqs.pop_front());
        in_gap = (((req_cnt / 16) % 4) == 3) ? 0 : $urandom_range(0, 7);
      end
      if (in_valid && !in_taken) begin
        // Hold: the current request is still stalled.
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        in_valid <= 1'b1;
        in_command <= pending_reqs[0].cmd;
        in_value <= pending_reqs[0].value;
        in_min_digits <= pending_reqs[0].min_digits;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall: after each accepted character, stall for a random count.
  // Every fourth block of fifty characters runs without stall.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_taken) begin
        stall_left = (((char_cnt / 50) % 4) == 2) ? 0 : $urandom_range(0, 7);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Sample both handshakes at the rising edge: predict on each accepted
  // request, compare each accepted character with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
      out_taken <= 1'b0;
    end else if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      cycle_cnt++;
      in_taken <= in_valid && !in_stall;
      out_taken <= out_valid && !out_stall;
      if (in_valid && !in_stall) begin
        predict_text(in_command, in_value, in_min_digits);
        req_cnt++;
      end
      if (out_valid && !out_stall) begin
        char_cnt++;
        if (expected_text.size() == 0) begin
          error_cnt++;
          if (error_cnt <= MAX_REPORTS) begin
            $display("Unexpected character 0x%02h last %0b at cycle %0d",
                     out_character, out_last, cycle_cnt);
          end
        end else begin
          if (out_character !== expected_text[0].ch || out_last !== expected_text[0].last) begin
            error_cnt++;
            if (error_cnt <= MAX_REPORTS) begin
              $display("Mismatch at cycle %0d: character exp 0x%02h got 0x%02h, last exp %0b got %0b",
                       cycle_cnt, expected_text[0].ch, out_character,
                       expected_text[0].last, out_last);
            end
          end
          void'(expected_text.pop_front());
        end
      end
    end
  end

endmodule

// ===== files.f =====
+incdir+design
design/itadf_pkg.sv
design/itadf_serializer.sv
design/int_to_ascii_dec_hex_formatter.sv
tb/tb_int_to_ascii_dec_hex_formatter.sv
